// ===== sv/pbrm_pkg.sv =====
`default_nettype none

package pbrm_pkg;

  localparam int MAP_PAGES = 65536;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int MAP_WORDS = (MAP_PAGES + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int POS_W     = ($clog2(MAP_PAGES + 1) > 18) ? $clog2(MAP_PAGES + 1) : 18;
  localparam int POP_W     = BIT_W + 1;

  localparam int CMD_W     = 2;
  localparam int PAGE_W    = 16;
  localparam int CNT_W     = 17;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(65536);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOCK      = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_RESERVE   = 2'd2,
    CMD_UNRESERVE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_MOD,
    S_ACC,
    S_DONE
  } state_e;

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [POP_W-1:0] k);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W+1)'(k);
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] v,
                                               input logic [POP_W-1:0] k);
    return (v >= CNT_W'(k)) ? (v - CNT_W'(k)) : '0;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pbrm_if.sv =====
`default_nettype none

interface pbrm_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [pbrm_pkg::CMD_W-1:0]  command;
  logic [pbrm_pkg::PAGE_W-1:0] start_page;
  logic [pbrm_pkg::CNT_W-1:0]  page_count;

  modport source (output valid, command, start_page, page_count, input ready);
  modport sink (input valid, command, start_page, page_count, output ready);
endinterface

interface pbrm_res_if;
  logic                      valid;
  logic                      ready;
  logic [pbrm_pkg::CNT_W-1:0] free_pages;
  logic [pbrm_pkg::CNT_W-1:0] used_pages;
  logic [pbrm_pkg::CNT_W-1:0] reserved_pages;
  logic [pbrm_pkg::CNT_W-1:0] pages_changed;
  logic                      out_of_range;

  modport source (output valid, free_pages, used_pages, reserved_pages, pages_changed,
                  out_of_range, input ready);
  modport sink (input valid, free_pages, used_pages, reserved_pages, pages_changed,
                out_of_range, output ready);
endinterface

`default_nettype wire

// ===== sv/page_bitmap_range_marker_unit.sv =====
// Page bitmap allocator: one busy bit per page held in a 64-bit wide synchronous memory,
// plus free, used and reserved page counters. Each command transfer marks a page range and
// yields one result transfer. Each 64-page word that the range covers inside the map costs
// one read and one write-back of the bitmap memory; a command with a zero page count goes
// straight to its result without touching the memory. A result that is still waiting holds
// the block in its last state for as long as it waits. After reset the bitmap memory is
// cleared one word a cycle, all 1024 words of it, and no command is taken until
// then. A write to total_pages reloads the free counter and is taken at any time, but should
// be made only while no command is in flight.
`default_nettype none

module page_bitmap_range_marker_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [pbrm_pkg::CNT_W-1:0]       cfg_wdata_i,
  pbrm_cmd_if.sink                         cmd_i,
  pbrm_res_if.source                       res_o
);

  localparam logic [pbrm_pkg::WIDX_W-1:0] LAST_WORD = pbrm_pkg::WIDX_W'(pbrm_pkg::MAP_WORDS - 1);
  localparam logic [pbrm_pkg::POS_W-1:0]  MAP_END   = pbrm_pkg::POS_W'(pbrm_pkg::MAP_PAGES);

  pbrm_pkg::state_e state_q, state_d;
  pbrm_pkg::cmd_e   cmd_q;

  logic [pbrm_pkg::WORD_W-1:0] mem_q [pbrm_pkg::MAP_WORDS];
  logic [pbrm_pkg::WORD_W-1:0] rd_data_q;
  logic [pbrm_pkg::WORD_W-1:0] mask_q, mask_d;
  logic [pbrm_pkg::WORD_W-1:0] flips;
  logic                        mem_we, mem_re;
  logic [pbrm_pkg::WIDX_W-1:0] mem_waddr, rd_word;
  logic [pbrm_pkg::WORD_W-1:0] mem_wdata;

  logic [pbrm_pkg::WIDX_W-1:0] word_q, first_word_q, last_word_q;
  logic [pbrm_pkg::BIT_W-1:0]  first_bit_q, last_bit_q, lo_bit, hi_bit;
  logic [pbrm_pkg::POP_W-1:0]  pop_q;

  logic [pbrm_pkg::CNT_W-1:0] free_q, used_q, rsvd_q, changed_q;
  logic                       oor_q;
  logic                       out_valid_q;
  logic [pbrm_pkg::CNT_W-1:0] out_free_q, out_used_q, out_rsvd_q, out_changed_q;
  logic                       out_oor_q;

  logic [pbrm_pkg::POS_W-1:0] start_pos, end_pos, clip_pos, last_pos;
  logic                       range_empty, range_oor;
  logic                       set_op, at_last, cmd_xfer, out_load;

  assign cmd_xfer = cmd_i.valid && cmd_i.ready;
  assign set_op   = (cmd_q == pbrm_pkg::CMD_LOCK) || (cmd_q == pbrm_pkg::CMD_RESERVE);
  assign at_last  = (word_q == last_word_q);
  assign out_load = (state_q == pbrm_pkg::S_DONE) && (!out_valid_q || res_o.ready);

  assign start_pos   = pbrm_pkg::POS_W'(cmd_i.start_page);
  assign end_pos     = start_pos + pbrm_pkg::POS_W'(cmd_i.page_count);
  assign clip_pos    = (end_pos > MAP_END) ? MAP_END : end_pos;
  assign last_pos    = clip_pos - pbrm_pkg::POS_W'(1);
  assign range_empty = (start_pos >= clip_pos);
  assign range_oor   = (cmd_i.page_count != '0) && (end_pos > MAP_END);

  assign rd_word = (state_q == pbrm_pkg::S_ACC) ? (word_q + pbrm_pkg::WIDX_W'(1)) : word_q;
  assign lo_bit  = (rd_word == first_word_q) ? first_bit_q : '0;
  assign hi_bit  = (rd_word == last_word_q) ? last_bit_q : '1;
  assign mask_d  = ({pbrm_pkg::WORD_W{1'b1}} << lo_bit)
                 & ({pbrm_pkg::WORD_W{1'b1}} >> (~hi_bit));

  assign flips = set_op ? (mask_q & ~rd_data_q) : (mask_q & rd_data_q);

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = word_q;
    mem_wdata = '0;
    case (state_q)
      pbrm_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (word_q == LAST_WORD) state_d = pbrm_pkg::S_IDLE;
      end
      pbrm_pkg::S_IDLE: begin
        if (cmd_xfer) state_d = range_empty ? pbrm_pkg::S_DONE : pbrm_pkg::S_RD;
      end
      pbrm_pkg::S_RD: begin
        mem_re  = 1'b1;
        state_d = pbrm_pkg::S_MOD;
      end
      pbrm_pkg::S_MOD: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_q ^ flips;
        state_d   = pbrm_pkg::S_ACC;
      end
      pbrm_pkg::S_ACC: begin
        mem_re  = !at_last;
        state_d = at_last ? pbrm_pkg::S_DONE : pbrm_pkg::S_MOD;
      end
      pbrm_pkg::S_DONE: begin
        if (out_load) state_d = pbrm_pkg::S_IDLE;
      end
      default: state_d = pbrm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem_q[rd_word];
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) mask_q <= mask_d;
    if (state_q == pbrm_pkg::S_MOD) pop_q <= pbrm_pkg::popcount(flips);
    if (cmd_xfer) begin
      cmd_q        <= pbrm_pkg::cmd_e'(cmd_i.command);
      first_word_q <= pbrm_pkg::WIDX_W'(start_pos >> pbrm_pkg::BIT_W);
      first_bit_q  <= start_pos[pbrm_pkg::BIT_W-1:0];
      last_word_q  <= pbrm_pkg::WIDX_W'(last_pos >> pbrm_pkg::BIT_W);
      last_bit_q   <= last_pos[pbrm_pkg::BIT_W-1:0];
      oor_q        <= range_oor;
    end
    if (out_load) begin
      out_free_q    <= free_q;
      out_used_q    <= used_q;
      out_rsvd_q    <= rsvd_q;
      out_changed_q <= changed_q;
      out_oor_q     <= oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbrm_pkg::S_CLEAR;
      word_q      <= '0;
      free_q      <= pbrm_pkg::CNT_RESET;
      used_q      <= '0;
      rsvd_q      <= '0;
      changed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        pbrm_pkg::S_CLEAR: word_q <= word_q + pbrm_pkg::WIDX_W'(1);
        pbrm_pkg::S_IDLE: begin
          if (cmd_xfer) begin
            word_q    <= pbrm_pkg::WIDX_W'(start_pos >> pbrm_pkg::BIT_W);
            changed_q <= '0;
          end
        end
        pbrm_pkg::S_ACC: begin
          changed_q <= changed_q + pbrm_pkg::CNT_W'(pop_q);
          if (!at_last) word_q <= word_q + pbrm_pkg::WIDX_W'(1);
          case (cmd_q)
            pbrm_pkg::CMD_LOCK: begin
              free_q <= pbrm_pkg::sat_sub(free_q, pop_q);
              used_q <= pbrm_pkg::sat_add(used_q, pop_q);
            end
            pbrm_pkg::CMD_FREE: begin
              free_q <= pbrm_pkg::sat_add(free_q, pop_q);
              used_q <= pbrm_pkg::sat_sub(used_q, pop_q);
            end
            pbrm_pkg::CMD_RESERVE: begin
              free_q <= pbrm_pkg::sat_sub(free_q, pop_q);
              rsvd_q <= pbrm_pkg::sat_add(rsvd_q, pop_q);
            end
            pbrm_pkg::CMD_UNRESERVE: begin
              free_q <= pbrm_pkg::sat_add(free_q, pop_q);
              rsvd_q <= pbrm_pkg::sat_sub(rsvd_q, pop_q);
            end
            default: free_q <= free_q;
          endcase
        end
        default: word_q <= word_q;
      endcase
      if (cfg_we_i) free_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_i.ready          = (state_q == pbrm_pkg::S_IDLE);
  assign res_o.valid          = out_valid_q;
  assign res_o.free_pages     = out_free_q;
  assign res_o.used_pages     = out_used_q;
  assign res_o.reserved_pages = out_rsvd_q;
  assign res_o.pages_changed  = out_changed_q;
  assign res_o.out_of_range   = out_oor_q;

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pbrm_pkg::S_DONE))
    else $error("result raised without a finished command");

  a_word_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbrm_pkg::S_MOD || state_q == pbrm_pkg::S_ACC) |->
      (word_q >= first_word_q && word_q <= last_word_q))
    else $error("bitmap word outside the command range");

  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbrm_pkg::S_MOD) |-> (mask_q != '0))
    else $error("empty page mask for a visited word");

  a_changed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbrm_pkg::S_ACC) |-> (pop_q <= pbrm_pkg::POP_W'(pbrm_pkg::WORD_W)))
    else $error("word flip count exceeds word width");

endmodule

`default_nettype wire

// ===== sim/page_bitmap_range_marker_unit_tb.sv =====
module page_bitmap_range_marker_unit_tb;
  import pbrm_pkg::*;

  typedef struct {
    cmd_e              op;
    logic [PAGE_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } range_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] free_pages;
    logic [CNT_W-1:0] used_pages;
    logic [CNT_W-1:0] reserved_pages;
    logic [CNT_W-1:0] pages_changed;
    logic             out_of_range;
  } page_tally_t;

  localparam int RANDOM_PER_SETTING = 270;
  localparam int NUM_SETTINGS       = 5;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;

  pbrm_cmd_if cmd_if ();
  pbrm_res_if res_if ();

  page_bitmap_range_marker_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  bit               page_busy [MAP_PAGES];
  logic [CNT_W-1:0] free_cnt     = CNT_RESET;
  logic [CNT_W-1:0] used_cnt     = '0;
  logic [CNT_W-1:0] reserved_cnt = '0;

  range_cmd_t  cmd_backlog [$];
  page_tally_t tally_q [$];

  bit cmd_taken = 1'b0;
  bit cmd_calm  = 1'b0;
  bit res_calm  = 1'b0;
  bit held      = 1'b0;
  int cmd_gap   = 0;
  int res_stall = 0;
  int hold_cnt  = 0;

  int fail_count   = 0;
  int cmds_sent    = 0;
  int results_seen = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic page_tally_t mark_range(input range_cmd_t c);
    page_tally_t t;
    bit          set_bits;
    int          stop;
    t        = '0;
    set_bits = (c.op == CMD_LOCK) || (c.op == CMD_RESERVE);
    stop     = int'(c.start) + int'(c.count);
    if (stop > MAP_PAGES) begin
      t.out_of_range = 1'b1;
      stop = MAP_PAGES;
    end
    for (int p = int'(c.start); p < stop; p++) begin
      if (page_busy[p] != set_bits) begin
        page_busy[p] = set_bits;
        t.pages_changed++;
        if (set_bits) begin
          free_cnt = count_down(free_cnt);
          if (c.op == CMD_LOCK) used_cnt = count_up(used_cnt);
          else reserved_cnt = count_up(reserved_cnt);
        end else begin
          free_cnt = count_up(free_cnt);
          if (c.op == CMD_FREE) used_cnt = count_down(used_cnt);
          else reserved_cnt = count_down(reserved_cnt);
        end
      end
    end
    t.free_pages     = free_cnt;
    t.used_pages     = used_cnt;
    t.reserved_pages = reserved_cnt;
    return t;
  endfunction

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic range_cmd_t random_range_cmd();
    range_cmd_t  c;
    int unsigned r;
    c.op = cmd_e'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 55) c.start = PAGE_W'($urandom_range(0, 4095));
    else if (r < 90) c.start = PAGE_W'($urandom);
    else c.start = PAGE_W'($urandom_range(65280, 65535));
    r = $urandom_range(0, 99);
    if (r < 5) c.count = '0;
    else if (r < 70) c.count = CNT_W'($urandom_range(1, 70));
    else if (r < 95) c.count = CNT_W'($urandom_range(71, 700));
    else if (r < 98) c.count = CNT_W'($urandom_range(701, 8192));
    else c.count = CNT_W'($urandom_range(8193, 131071));
    return c;
  endfunction

  task automatic queue_cmd(input cmd_e op, input logic [PAGE_W-1:0] start,
                           input logic [CNT_W-1:0] count);
    range_cmd_t c;
    c.op    = op;
    c.start = start;
    c.count = count;
    cmd_backlog.push_back(c);
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || cmd_if.valid === 1'b1 || tally_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_total(input logic [CNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    free_cnt     = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    range_cmd_t c;
    if ($urandom_range(0, 149) == 0) cmd_calm = !cmd_calm;
    if (cmd_if.valid !== 1'b1 || cmd_taken) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_if.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        c = cmd_backlog.pop_front();
        cmd_if.command    <= c.op;
        cmd_if.start_page <= c.start;
        cmd_if.page_count <= c.count;
        cmd_if.valid      <= 1'b1;
        cmd_gap = cmd_calm ? 0 : idle_len();
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
  end

  always @(posedge clk_i) begin
    range_cmd_t c;
    if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
      c.op    = cmd_e'(cmd_if.command);
      c.start = cmd_if.start_page;
      c.count = cmd_if.page_count;
      tally_q.push_back(mark_range(c));
      cmd_taken = 1'b1;
      cmds_sent++;
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 149) == 0) res_calm = !res_calm;
    // A long hold-off lets the block fill up while commands keep being offered.
    if (!held && results_seen >= 150) begin
      held     = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      res_if.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_stall--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      res_stall = res_calm ? 0 : idle_len();
    end
  end

  always @(posedge clk_i) begin
    page_tally_t want;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (tally_q.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        want = tally_q.pop_front();
        if (res_if.free_pages !== want.free_pages) begin
          $error("free_pages: expected %0d, got %0d", want.free_pages, res_if.free_pages);
          fail_count++;
        end
        if (res_if.used_pages !== want.used_pages) begin
          $error("used_pages: expected %0d, got %0d", want.used_pages, res_if.used_pages);
          fail_count++;
        end
        if (res_if.reserved_pages !== want.reserved_pages) begin
          $error("reserved_pages: expected %0d, got %0d", want.reserved_pages,
                 res_if.reserved_pages);
          fail_count++;
        end
        if (res_if.pages_changed !== want.pages_changed) begin
          $error("pages_changed: expected %0d, got %0d", want.pages_changed,
                 res_if.pages_changed);
          fail_count++;
        end
        if (res_if.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                 res_if.out_of_range);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #25000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [CNT_W-1:0] settings [NUM_SETTINGS];
    range_cmd_t       c;
    range_cmd_t       prev;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_LOCK;
    cmd_if.start_page = '0;
    cmd_if.page_count = '0;
    res_if.ready      = 1'b0;
    settings[0] = CNT_RESET;
    settings[1] = '0;
    settings[2] = CNT_MAX;
    settings[3] = CNT_W'($urandom_range(1, 131070));
    settings[4] = CNT_W'(1);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      write_total(settings[s]);
      case (s)
        0: begin
          queue_cmd(CMD_LOCK, 16'd0, 17'd0);
          queue_cmd(CMD_LOCK, 16'd0, 17'd1);
          queue_cmd(CMD_LOCK, 16'd0, 17'd1);
          queue_cmd(CMD_RESERVE, 16'd0, 17'd64);
          queue_cmd(CMD_FREE, 16'd10, 17'd5);
          queue_cmd(CMD_UNRESERVE, 16'd0, 17'd128);
          queue_cmd(CMD_RESERVE, 16'd32, 17'd100);
          queue_cmd(CMD_LOCK, 16'd65530, 17'd20);
          queue_cmd(CMD_FREE, 16'hFFFF, 17'd65536);
          queue_cmd(CMD_UNRESERVE, 16'hFFFF, 17'd1);
          queue_cmd(CMD_LOCK, 16'd100, CNT_MAX);
          queue_cmd(CMD_UNRESERVE, 16'd0, 17'd65536);
          queue_cmd(CMD_LOCK, 16'd0, 17'd65536);
          queue_cmd(CMD_UNRESERVE, 16'd0, 17'd65536);
          queue_cmd(CMD_LOCK, 16'd0, 17'd65536);
          queue_cmd(CMD_FREE, 16'd0, 17'd65536);
          queue_cmd(CMD_RESERVE, 16'hFFFF, 17'd2);
          queue_cmd(CMD_UNRESERVE, 16'hFFFF, 17'd1);
        end
        1: begin
          queue_cmd(CMD_LOCK, 16'd0, 17'd4096);
        end
        2: begin
          queue_cmd(CMD_FREE, 16'd0, 17'd65536);
        end
        default: begin
        end
      endcase
      prev = random_range_cmd();
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        c = random_range_cmd();
        if (n > 0 && $urandom_range(0, 2) == 0) begin
          c.op    = cmd_e'(prev.op ^ 2'b01);
          c.start = prev.start;
          c.count = prev.count;
        end
        cmd_backlog.push_back(c);
        prev = c;
      end
    end
    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Run covered %0d command transfers and %0d result transfers over %0d settings",
             cmds_sent, results_seen, NUM_SETTINGS);
    $display("of total_pages, including a long result hold-off; %0d failures were seen.",
             fail_count);
    if (fail_count == 0 && tally_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
